[rtl/rpcf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcf_pkg: shared types and constants of the roll/pitch complementary filter
// Holds the command word, state codes, register image and CORDIC angle table.
// ----------------------------------------------------------------------------
package rpcf_pkg;

	localparam int CORDIC_STEPS = 16;          // 8..24
	localparam int SQRT_STEPS   = 30;          // radicand below 2^60, two bits a step
	localparam int DIV_STEPS    = 3;           // estimate, remainder, fix-up
	localparam int CNT_W        = 6;

	localparam logic [19:0] US_PER_S   = 20'd1000000;
	localparam logic [21:0] TWO_S      = 22'd2000000;
	localparam logic [31:0] US_RECIP   = 32'd2251799813;   // floor(2^51 / 1e6)
	localparam logic [39:0] HALF_S     = 40'd500000;
	localparam logic [18:0] QUARTER_TURN = 19'd23040;   // 90 deg in 1/256 deg
	localparam logic signed [25:0] RIGHT_ANG = 26'sd5898240;  // 90 deg, 1/65536
	localparam logic signed [24:0] ANG_MAX = 25'sd262143;
	localparam logic signed [24:0] ANG_MIN = -25'sd262144;

	localparam logic [1:0] REG_BLEND   = 2'd0;
	localparam logic [1:0] REG_DEFAULT = 2'd1;
	localparam logic [1:0] REG_MIN     = 2'd2;
	localparam logic [1:0] REG_MAX     = 2'd3;

	// divide sub-steps
	localparam logic [4:0] DIV_EST = 5'd0;
	localparam logic [4:0] DIV_REM = 5'd1;
	localparam logic [4:0] DIV_FIX = 5'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_DT,
		OP_SQY,
		OP_SQZ,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_CORD_INIT,
		OP_CORD_STEP,
		OP_CORD_DONE,
		OP_GYRO_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_BLEND_G,
		OP_BLEND_M1,
		OP_BLEND_M2,
		OP_BLEND_SUM,
		OP_EMIT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DT,
		ST_SQY,
		ST_SQZ,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_CR_INIT,
		ST_CR_STEP,
		ST_CR_DONE,
		ST_CP_INIT,
		ST_CP_STEP,
		ST_CP_DONE,
		ST_GMUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_BL_G,
		ST_BL_M1,
		ST_BL_M2,
		ST_BL_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t        op;
		logic       axis;   // 0 roll, 1 pitch
		logic [4:0] step;
	} cmd_t;

	typedef struct packed {
		logic [15:0] blend;
		logic [19:0] dflt;
		logic [19:0] dmin;
		logic [19:0] dmax;
	} cfg_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [25:0] atan_ang(input logic [4:0] i);
		logic signed [25:0] v;
		unique case (i)
			5'd0:  v = 26'sd2949120;
			5'd1:  v = 26'sd1740967;
			5'd2:  v = 26'sd919879;
			5'd3:  v = 26'sd466945;
			5'd4:  v = 26'sd234379;
			5'd5:  v = 26'sd117304;
			5'd6:  v = 26'sd58666;
			5'd7:  v = 26'sd29335;
			5'd8:  v = 26'sd14668;
			5'd9:  v = 26'sd7334;
			5'd10: v = 26'sd3667;
			5'd11: v = 26'sd1833;
			5'd12: v = 26'sd917;
			5'd13: v = 26'sd458;
			5'd14: v = 26'sd229;
			5'd15: v = 26'sd115;
			5'd16: v = 26'sd57;
			5'd17: v = 26'sd29;
			5'd18: v = 26'sd14;
			5'd19: v = 26'sd7;
			5'd20: v = 26'sd4;
			5'd21: v = 26'sd2;
			5'd22: v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/rpcf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcf_ctrl: sequencer of the filter
// Steps the datapath through dt, sqrt, two CORDICs, divide and blend per axis.
// ----------------------------------------------------------------------------
module rpcf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rpcf_pkg::cmd_t     cmd
);

	rpcf_pkg::state_t state_q, state_d;
	logic [rpcf_pkg::CNT_W-1:0] cnt_q;
	logic axis_q;
	logic ovalid_q;
	logic emit;

	localparam logic [rpcf_pkg::CNT_W-1:0] SQRT_LAST = rpcf_pkg::CNT_W'(rpcf_pkg::SQRT_STEPS - 1);
	localparam logic [rpcf_pkg::CNT_W-1:0] CORD_LAST = rpcf_pkg::CNT_W'(rpcf_pkg::CORDIC_STEPS - 1);
	localparam logic [rpcf_pkg::CNT_W-1:0] DIV_LAST  = rpcf_pkg::CNT_W'(rpcf_pkg::DIV_STEPS - 1);

	assign emit = (state_q == rpcf_pkg::ST_OUT) && (!ovalid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpcf_pkg::ST_IDLE:      if (in_valid) state_d = rpcf_pkg::ST_DIFF;
			rpcf_pkg::ST_DIFF:      state_d = rpcf_pkg::ST_DT;
			rpcf_pkg::ST_DT:        state_d = rpcf_pkg::ST_SQY;
			rpcf_pkg::ST_SQY:       state_d = rpcf_pkg::ST_SQZ;
			rpcf_pkg::ST_SQZ:       state_d = rpcf_pkg::ST_SQRT_INIT;
			rpcf_pkg::ST_SQRT_INIT: state_d = rpcf_pkg::ST_SQRT;
			rpcf_pkg::ST_SQRT:      if (cnt_q == SQRT_LAST) state_d = rpcf_pkg::ST_CR_INIT;
			rpcf_pkg::ST_CR_INIT:   state_d = rpcf_pkg::ST_CR_STEP;
			rpcf_pkg::ST_CR_STEP:   if (cnt_q == CORD_LAST) state_d = rpcf_pkg::ST_CR_DONE;
			rpcf_pkg::ST_CR_DONE:   state_d = rpcf_pkg::ST_CP_INIT;
			rpcf_pkg::ST_CP_INIT:   state_d = rpcf_pkg::ST_CP_STEP;
			rpcf_pkg::ST_CP_STEP:   if (cnt_q == CORD_LAST) state_d = rpcf_pkg::ST_CP_DONE;
			rpcf_pkg::ST_CP_DONE:   state_d = rpcf_pkg::ST_GMUL;
			rpcf_pkg::ST_GMUL:      state_d = rpcf_pkg::ST_DIV_INIT;
			rpcf_pkg::ST_DIV_INIT:  state_d = rpcf_pkg::ST_DIV;
			rpcf_pkg::ST_DIV:       if (cnt_q == DIV_LAST) state_d = rpcf_pkg::ST_BL_G;
			rpcf_pkg::ST_BL_G:      state_d = rpcf_pkg::ST_BL_M1;
			rpcf_pkg::ST_BL_M1:     state_d = rpcf_pkg::ST_BL_M2;
			rpcf_pkg::ST_BL_M2:     state_d = rpcf_pkg::ST_BL_SUM;
			rpcf_pkg::ST_BL_SUM:    state_d = axis_q ? rpcf_pkg::ST_OUT : rpcf_pkg::ST_GMUL;
			rpcf_pkg::ST_OUT:       if (emit) state_d = rpcf_pkg::ST_IDLE;
			default:                state_d = rpcf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = rpcf_pkg::OP_NONE;
		cmd.axis = axis_q;
		cmd.step = cnt_q[4:0];
		unique case (state_q)
			rpcf_pkg::ST_IDLE:      if (in_valid) cmd.op = rpcf_pkg::OP_LOAD;
			rpcf_pkg::ST_DIFF:      cmd.op = rpcf_pkg::OP_DIFF;
			rpcf_pkg::ST_DT:        cmd.op = rpcf_pkg::OP_DT;
			rpcf_pkg::ST_SQY:       cmd.op = rpcf_pkg::OP_SQY;
			rpcf_pkg::ST_SQZ:       cmd.op = rpcf_pkg::OP_SQZ;
			rpcf_pkg::ST_SQRT_INIT: cmd.op = rpcf_pkg::OP_SQRT_INIT;
			rpcf_pkg::ST_SQRT:      cmd.op = rpcf_pkg::OP_SQRT_STEP;
			rpcf_pkg::ST_CR_INIT: begin
				cmd.op = rpcf_pkg::OP_CORD_INIT; cmd.axis = 1'b0;
			end
			rpcf_pkg::ST_CR_STEP: begin
				cmd.op = rpcf_pkg::OP_CORD_STEP; cmd.axis = 1'b0;
			end
			rpcf_pkg::ST_CR_DONE: begin
				cmd.op = rpcf_pkg::OP_CORD_DONE; cmd.axis = 1'b0;
			end
			rpcf_pkg::ST_CP_INIT: begin
				cmd.op = rpcf_pkg::OP_CORD_INIT; cmd.axis = 1'b1;
			end
			rpcf_pkg::ST_CP_STEP: begin
				cmd.op = rpcf_pkg::OP_CORD_STEP; cmd.axis = 1'b1;
			end
			rpcf_pkg::ST_CP_DONE: begin
				cmd.op = rpcf_pkg::OP_CORD_DONE; cmd.axis = 1'b1;
			end
			rpcf_pkg::ST_GMUL:      cmd.op = rpcf_pkg::OP_GYRO_MUL;
			rpcf_pkg::ST_DIV_INIT:  cmd.op = rpcf_pkg::OP_DIV_INIT;
			rpcf_pkg::ST_DIV:       cmd.op = rpcf_pkg::OP_DIV_STEP;
			rpcf_pkg::ST_BL_G:      cmd.op = rpcf_pkg::OP_BLEND_G;
			rpcf_pkg::ST_BL_M1:     cmd.op = rpcf_pkg::OP_BLEND_M1;
			rpcf_pkg::ST_BL_M2:     cmd.op = rpcf_pkg::OP_BLEND_M2;
			rpcf_pkg::ST_BL_SUM:    cmd.op = rpcf_pkg::OP_BLEND_SUM;
			rpcf_pkg::ST_OUT:       if (emit) cmd.op = rpcf_pkg::OP_EMIT;
			default:                cmd.op = rpcf_pkg::OP_NONE;
		endcase
	end

	assign in_ready  = (state_q == rpcf_pkg::ST_IDLE);
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rpcf_pkg::ST_IDLE;
			cnt_q    <= '0;
			axis_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rpcf_pkg::ST_SQRT || state_q == rpcf_pkg::ST_CR_STEP ||
			    state_q == rpcf_pkg::ST_CP_STEP || state_q == rpcf_pkg::ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (state_q == rpcf_pkg::ST_DIFF)
				axis_q <= 1'b0;
			else if (state_q == rpcf_pkg::ST_BL_SUM)
				axis_q <= 1'b1;
			if (emit)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

[rtl/rpcf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcf_dp: datapath of the filter
// dt clamp, bit-pair sqrt, shared CORDIC, reciprocal divide by 1e6, blend.
// ----------------------------------------------------------------------------
module rpcf_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpcf_pkg::cmd_t     cmd,
	input  wire rpcf_pkg::cfg_t     cfg,
	input  wire logic [62:0]        time_us,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] rate_x,
	input  wire logic signed [15:0] rate_y,
	output logic signed [18:0]      roll_angle,
	output logic signed [18:0]      pitch_angle
);

	logic [62:0] now_q, last_q, diff_q;
	logic        back_q;
	logic signed [15:0] ax_q, ay_q, az_q, rx_q, ry_q;
	logic [19:0] dt_q;
	logic [31:0] sqy_q, sqz_q;
	logic [59:0] sv_q, sr_q, sb_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [25:0] cz_q;
	logic czero_q;
	logic signed [18:0] accr_q, accp_q;
	logic [35:0] prod_q;
	logic neg_q;
	logic [39:0] dvd_q;
	logic [21:0] rem_q;
	logic [20:0] quo_q;
	logic signed [21:0] g_q;
	logic signed [39:0] p1_q;
	logic signed [36:0] p2_q;
	logic signed [18:0] roll_q, pitch_q, oroll_q, opitch_q;

	// combinational helpers
	logic [19:0] dt_d;
	logic [59:0] s_try;
	logic signed [35:0] x0, y0, xs, ys;
	logic signed [25:0] zr;
	logic signed [18:0] acc_d;
	logic signed [16:0] rate_sel;
	logic [16:0] mag;
	logic [36:0] prod_d;
	logic [52:0] est_d;
	logic [40:0] qm_d;
	logic [39:0] rdiff;
	logic signed [21:0] inc, prev;
	logic signed [17:0] wa, wb;
	logic signed [40:0] sum;
	logic signed [24:0] shr;
	logic signed [18:0] sat;

	always_comb begin
		if (last_q == '0)
			dt_d = cfg.dflt;
		else if (back_q)
			dt_d = (cfg.dmin > cfg.dmax) ? cfg.dmax : cfg.dmin;
		else if (diff_q < {43'd0, cfg.dmin})
			dt_d = (cfg.dmin > cfg.dmax) ? cfg.dmax : cfg.dmin;
		else if (diff_q > {43'd0, cfg.dmax})
			dt_d = cfg.dmax;
		else
			dt_d = diff_q[19:0];
	end

	assign s_try = sr_q + sb_q;

	always_comb begin
		if (cmd.axis) begin
			x0 = $signed({6'd0, sr_q[29:0]});
			y0 = -($signed({{6{ax_q[15]}}, ax_q, 14'd0}));
		end else begin
			x0 = $signed({{6{az_q[15]}}, az_q, 14'd0});
			y0 = -($signed({{6{ay_q[15]}}, ay_q, 14'd0}));
		end
		xs = cx_q >>> cmd.step;
		ys = cy_q >>> cmd.step;
		zr = (cz_q + 26'sd128) >>> 8;
		acc_d = czero_q ? 19'sd0 : zr[18:0];
		rate_sel = cmd.axis ? 17'(ry_q) : 17'(rx_q);
		mag = rate_sel[16] ? 17'(-rate_sel) : 17'(rate_sel);
		prod_d = {20'd0, mag} * {17'd0, dt_q};
		// quotient estimate from the top dividend bits, low by at most two
		est_d = {32'd0, dvd_q[39:19]} * {21'd0, rpcf_pkg::US_RECIP};
		qm_d = {20'd0, quo_q} * {21'd0, rpcf_pkg::US_PER_S};
		rdiff = dvd_q - qm_d[39:0];
		inc = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		prev = cmd.axis ? 22'(pitch_q) : 22'(roll_q);
		wa = $signed({2'b00, cfg.blend});
		wb = $signed(18'd65536 - {2'b00, cfg.blend});
		sum = 41'(p1_q) + 41'(p2_q) + 41'sd32768;
		shr = sum[40:16];
		if (shr > rpcf_pkg::ANG_MAX)
			sat = 19'sd262143;
		else if (shr < rpcf_pkg::ANG_MIN)
			sat = -19'sd262144;
		else
			sat = shr[18:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			roll_q  <= '0;
			pitch_q <= '0;
		end else begin
			if (cmd.op == rpcf_pkg::OP_DT)
				last_q <= now_q;
			if (cmd.op == rpcf_pkg::OP_BLEND_SUM) begin
				if (cmd.axis) pitch_q <= sat;
				else          roll_q  <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rpcf_pkg::OP_LOAD: begin
				now_q <= time_us;
				ax_q <= accel_x; ay_q <= accel_y; az_q <= accel_z;
				rx_q <= rate_x;  ry_q <= rate_y;
			end
			rpcf_pkg::OP_DIFF: begin
				diff_q <= now_q - last_q;
				back_q <= now_q < last_q;
			end
			rpcf_pkg::OP_DT:  dt_q  <= dt_d;
			rpcf_pkg::OP_SQY: sqy_q <= 32'(ay_q) * 32'(ay_q);
			rpcf_pkg::OP_SQZ: sqz_q <= 32'(az_q) * 32'(az_q);
			rpcf_pkg::OP_SQRT_INIT: begin
				sv_q <= {(sqy_q + sqz_q), 28'd0};
				sr_q <= '0;
				sb_q <= 60'd1 << 58;
			end
			rpcf_pkg::OP_SQRT_STEP: begin
				if (sv_q >= s_try) begin
					sv_q <= sv_q - s_try;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			rpcf_pkg::OP_CORD_INIT: begin
				czero_q <= (x0 == '0) && (y0 == '0);
				if (x0 < 0) begin
					if (y0 >= 0) begin
						cx_q <= y0; cy_q <= -x0; cz_q <= rpcf_pkg::RIGHT_ANG;
					end else begin
						cx_q <= -y0; cy_q <= x0; cz_q <= -rpcf_pkg::RIGHT_ANG;
					end
				end else begin
					cx_q <= x0; cy_q <= y0; cz_q <= '0;
				end
			end
			rpcf_pkg::OP_CORD_STEP: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys; cy_q <= cy_q - xs;
					cz_q <= cz_q + rpcf_pkg::atan_ang(cmd.step);
				end else begin
					cx_q <= cx_q - ys; cy_q <= cy_q + xs;
					cz_q <= cz_q - rpcf_pkg::atan_ang(cmd.step);
				end
			end
			rpcf_pkg::OP_CORD_DONE: begin
				if (cmd.axis) accp_q <= acc_d;
				else          accr_q <= acc_d - $signed(rpcf_pkg::QUARTER_TURN);
			end
			rpcf_pkg::OP_GYRO_MUL: begin
				prod_q <= prod_d[35:0];
				neg_q  <= rate_sel[16];
			end
			rpcf_pkg::OP_DIV_INIT: begin
				dvd_q <= {prod_q, 4'd0} + rpcf_pkg::HALF_S;
				rem_q <= '0;
				quo_q <= '0;
			end
			rpcf_pkg::OP_DIV_STEP: begin
				unique case (cmd.step)
					rpcf_pkg::DIV_EST: quo_q <= est_d[52:32];
					rpcf_pkg::DIV_REM: rem_q <= rdiff[21:0];
					rpcf_pkg::DIV_FIX: begin
						if (rem_q >= rpcf_pkg::TWO_S)
							quo_q <= quo_q + 21'd2;
						else if (rem_q >= {2'b00, rpcf_pkg::US_PER_S})
							quo_q <= quo_q + 21'd1;
					end
					default: ;
				endcase
			end
			rpcf_pkg::OP_BLEND_G:  g_q  <= prev + inc;
			rpcf_pkg::OP_BLEND_M1: p1_q <= 40'(wa) * 40'(g_q);
			rpcf_pkg::OP_BLEND_M2: p2_q <= 37'(wb) * 37'(cmd.axis ? accp_q : accr_q);
			rpcf_pkg::OP_EMIT: begin
				oroll_q  <= roll_q;
				opitch_q <= pitch_q;
			end
			default: ;
		endcase
	end

	assign roll_angle  = oroll_q;
	assign pitch_angle = opitch_q;

endmodule
`default_nettype wire

[rtl/roll_pitch_complementary_filter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roll_pitch_complementary_filter_unit: IMU roll/pitch complementary filter
// Blends integrated gyro rates with accel reference angles per sample.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes one IMU word: timestamp (us), three accels, two rates.
//  - Master stream gives one word per input: filtered roll and pitch,
//    1/256 degree, saturated to 19 bits signed.
//  - APB port holds blend weight and the dt default/min/max registers;
//    write them only while no word is in flight.
// Sequence: the 30-step square root and two 16-step CORDIC passes make up
//  most of the work per word; the gyro divide by 1e6 is a reciprocal
//  multiply with estimate, remainder and fix-up steps, run once per axis.
// s_tready is high only while the sequencer is idle. The finished result
//  sits in an output register, so the next word can be taken while the
//  receiver stalls; a second result then waits until the first is taken.
// Reset clears filter state, last timestamp (next word uses the default
//  dt) and loads register defaults.
// ----------------------------------------------------------------------------
module roll_pitch_complementary_filter_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// time_us[62:0], accel_x[78:63], accel_y[94:79], accel_z[110:95],
	// rate_x[126:111], rate_y[142:127], zero pad[143]
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// roll_angle[18:0], pitch_angle[37:19], zero pad[39:38]
	output logic [39:0]       m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	rpcf_pkg::cfg_t cfg_q;
	rpcf_pkg::cmd_t cmd;
	logic wr;
	logic signed [18:0] roll, pitch;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// register file, index from paddr[3:2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blend <= 16'd52429;
			cfg_q.dflt  <= 20'd10000;
			cfg_q.dmin  <= 20'd1000;
			cfg_q.dmax  <= 20'd50000;
		end else if (wr) begin
			unique case (paddr[3:2])
				rpcf_pkg::REG_BLEND:   cfg_q.blend <= pwdata[15:0];
				rpcf_pkg::REG_DEFAULT: cfg_q.dflt  <= pwdata[19:0];
				rpcf_pkg::REG_MIN:     cfg_q.dmin  <= pwdata[19:0];
				rpcf_pkg::REG_MAX:     cfg_q.dmax  <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rpcf_pkg::REG_BLEND:   prdata = {16'd0, cfg_q.blend};
			rpcf_pkg::REG_DEFAULT: prdata = {12'd0, cfg_q.dflt};
			rpcf_pkg::REG_MIN:     prdata = {12'd0, cfg_q.dmin};
			rpcf_pkg::REG_MAX:     prdata = {12'd0, cfg_q.dmax};
			default:               prdata = '0;
		endcase
	end

	rpcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	rpcf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.time_us     (s_tdata[62:0]),
		.accel_x     (s_tdata[78:63]),
		.accel_y     (s_tdata[94:79]),
		.accel_z     (s_tdata[110:95]),
		.rate_x      (s_tdata[126:111]),
		.rate_y      (s_tdata[142:127]),
		.roll_angle  (roll),
		.pitch_angle (pitch)
	);

	assign m_tdata = {2'b00, pitch, roll};

endmodule
`default_nettype wire

[dv/tb_roll_pitch_complementary_filter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_roll_pitch_complementary_filter_unit: self-checking bench for the filter
// Feeds IMU words through the slave stream, predicts roll/pitch in an
// in-bench fixed-point filter model and checks every master-side word.
// ----------------------------------------------------------------------------
module tb_roll_pitch_complementary_filter_unit;
	import rpcf_pkg::*;

	localparam int TB_WEIGHT  = 4 * int'(REG_BLEND);
	localparam int TB_DEFAULT = 4 * int'(REG_DEFAULT);
	localparam int TB_MIN     = 4 * int'(REG_MIN);
	localparam int TB_MAX     = 4 * int'(REG_MAX);
	localparam longint unsigned STAMP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint DEG90_Q8 = 90 * 256;

	typedef struct {
		longint unsigned stamp;
		logic signed [15:0] ax, ay, az, rx, ry;
	} imu_word_t;

	typedef struct {
		logic signed [18:0] roll;
		logic signed [18:0] pitch;
	} angle_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// bench copy of the filter: registers and state
	int unsigned alpha_q16 = 52429;
	int unsigned dt_default = 10000;
	int unsigned dt_floor = 1000;
	int unsigned dt_ceil = 50000;
	longint roll_state = 0;
	longint pitch_state = 0;
	longint unsigned prev_stamp = 0;

	angle_pair_t pending_angles[$];
	int errs = 0;
	bit no_idle = 1'b0;      // both sides run flat out while set
	int sink_hold = 0;       // one-shot long stall of the receiver, cycles
	longint unsigned clock_us = 1;

	// atan(2^-i) in 1/65536 degree
	longint arc_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
		7, 4, 2, 1, 0};

	roll_pitch_complementary_filter_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------
	function automatic longint vector_angle(longint y, longint x);
		longint z, nx, ny, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		// fold left half-plane onto the right by a quarter turn
		if (x < 0) begin
			if (y >= 0) begin
				nx = y; ny = -x; z = 90 * 65536;
			end else begin
				nx = -y; ny = x; z = -90 * 65536;
			end
			x = nx; y = ny;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z += arc_tab[i];
			end else begin
				x = x - ys; y = y + xs; z -= arc_tab[i];
			end
		end
		return z;
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// rate * dt * 16 / 1e6 in 1/256 degree, half away from zero
	function automatic longint rate_step(longint rate, int unsigned dt);
		longint unsigned q;
		q = ((rate < 0 ? -rate : rate) * longint'(dt) * 16 + 500000) / 1000000;
		return rate < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint mix_angle(longint prev, longint inc, longint ref_ang);
		longint r;
		r = (longint'(alpha_q16) * (prev + inc)
			+ (65536 - longint'(alpha_q16)) * ref_ang + 32768) >>> 16;
		if (r > 262143) r = 262143;
		if (r < -262144) r = -262144;
		return r;
	endfunction

	function automatic angle_pair_t filter_predict(imu_word_t w);
		int unsigned dt;
		longint unsigned d, mag;
		longint ax, ay, az, ref_roll, ref_pitch;
		angle_pair_t p;
		ax = w.ax; ay = w.ay; az = w.az;
		if (prev_stamp == 0) begin
			dt = dt_default;
		end else if (w.stamp < prev_stamp) begin
			dt = dt_floor > dt_ceil ? dt_ceil : dt_floor;
		end else begin
			d = w.stamp - prev_stamp;
			if (d < dt_floor) d = dt_floor;
			if (d > dt_ceil) d = dt_ceil;
			dt = int'(d);
		end
		prev_stamp = w.stamp;
		ref_roll = ((vector_angle(-ay * 16384, az * 16384) + 128) >>> 8) - DEG90_Q8;
		mag = floor_root(longint'(ay * ay + az * az) << 28);
		ref_pitch = (vector_angle(-ax * 16384, longint'(mag)) + 128) >>> 8;
		roll_state = mix_angle(roll_state, rate_step(w.rx, dt), ref_roll);
		pitch_state = mix_angle(pitch_state, rate_step(w.ry, dt), ref_pitch);
		p.roll = roll_state[18:0];
		p.pitch = pitch_state[18:0];
		return p;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// Send one word; valid stays high after acceptance until the next call.
	task automatic send_word(imu_word_t w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, w.ry, w.rx, w.az, w.ay, w.ax, w.stamp[62:0]};
		do @(posedge clk); while (!s_tready);
		pending_angles.push_back(filter_predict(w));
	endtask

	task automatic send_imu(longint unsigned t, int ax, int ay, int az, int rx, int ry);
		imu_word_t w;
		w.stamp = t; w.ax = ax; w.ay = ay; w.az = az; w.rx = rx; w.ry = ry;
		send_word(w);
	endtask

	// stop offering and wait until every expected word has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_angles.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// APB write: setup then access; only called with the filter idle
	task automatic reg_write(int addr, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= addr[3:0]; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (addr)
			TB_WEIGHT:  alpha_q16 = val & 32'hFFFF;
			TB_DEFAULT: dt_default = val & 32'hF_FFFF;
			TB_MIN:     dt_floor = val & 32'hF_FFFF;
			TB_MAX:     dt_ceil = val & 32'hF_FFFF;
			default: ;
		endcase
	endtask

	task automatic set_filter(int unsigned a, int unsigned d, int unsigned lo, int unsigned hi);
		reg_write(TB_WEIGHT, a);
		reg_write(TB_DEFAULT, d);
		reg_write(TB_MIN, lo);
		reg_write(TB_MAX, hi);
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(0, 4096)) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly steady sample clock; sometimes jumps, runs backward or reads 0
	function automatic longint unsigned next_stamp();
		int k;
		k = $urandom_range(0, 99);
		if (k < 4)
			clock_us = {$urandom, $urandom} & STAMP_MAX;
		else if (k < 7)
			clock_us = clock_us - (clock_us > 5000 ? $urandom_range(1, 5000) : 0);
		else if (k < 9)
			clock_us = 0;
		else if (k < 12)
			clock_us = (clock_us + $urandom_range(0, 1200000)) & STAMP_MAX;
		else
			clock_us = (clock_us + $urandom_range(500, 60000)) & STAMP_MAX;
		return clock_us;
	endfunction

	task automatic random_words(int n);
		imu_word_t w;
		repeat (n) begin
			w.stamp = next_stamp();
			w.ax = rand_axis(); w.ay = rand_axis(); w.az = rand_axis();
			w.rx = rand_axis(); w.ry = rand_axis();
			send_word(w);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// first sample at defaults; stamp 0 keeps the next one first as well
		send_imu(0, 0, 0, 2048, 0, 0);
		send_imu(0, 0, 0, 0, 0, 0);              // zero vector everywhere
		send_imu(1000, 0, 0, -2048, 160, -160);  // az negative, ay zero
		send_imu(2000, 0, 2048, 0, 0, 0);
		send_imu(1500, 100, -300, 1800, 32767, -32768); // backward step
		send_imu(1501, 0, 0, 0, 32767, 32767);   // tiny step clamps up
		send_imu(STAMP_MAX, -32768, -32768, -32768, -32768, -32768);
		send_imu(STAMP_MAX, 32767, 32767, 32767, 32767, 32767);
		send_imu(5, -32768, 32767, -32768, 1, -1); // far backward
		send_imu(200005, 32767, 0, 0, -32768, 32767); // long step clamps down
		send_imu(210005, -32768, 0, 0, 0, 0);
		send_imu(220005, 2048, -2048, 0, 16, 16);
		drain();
	endtask

	task automatic test_clamp_corners();
		// min above max: every measured step lands on max
		set_filter(65535, 1000000, 40000, 2000);
		send_imu(100, 0, 0, 2048, 32767, -32768);
		send_imu(50000, 300, 200, 1900, 32767, -32768);
		send_imu(10, 300, 200, 1900, -32767, 32767);
		drain();
		// zero registers: no gyro increment; alpha 0 tracks accel only
		set_filter(0, 0, 0, 0);
		send_imu(400, 500, -500, 1500, 32767, 32767);
		send_imu(900, -500, 500, -1500, -32768, 1);
		drain();
		// masked over-range writes
		set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_imu(1, 1, 2, 3, 32767, -32768);
		send_imu(2000000, 1, 2, 3, 32767, -32768);
		drain();
	endtask

	task automatic test_random_settings();
		set_filter(52429, 10000, 1000, 50000);
		random_words(320);
		drain();
		no_idle = 1'b1;
		set_filter($urandom_range(0, 65535), $urandom_range(1, 1000000),
			$urandom_range(1, 20000), $urandom_range(20000, 1000000));
		random_words(150);
		drain();
		no_idle = 1'b0;
		set_filter(65535, 1, 1, 1000000);
		random_words(150);
		drain();
		set_filter(1, 1000000, 1000000, 1);
		random_words(100);
		drain();
		set_filter($urandom, $urandom, $urandom, $urandom);
		random_words(150);
		drain();
	endtask

	task automatic test_backpressure();
		set_filter(52429, 10000, 1000, 50000);
		sink_hold = 1500;
		no_idle = 1'b1;
		random_words(8);
		no_idle = 1'b0;
		drain();
	endtask

	// ------------------------------------------------------------------
	// receiver: random stall per word plus one long hold on request
	// ------------------------------------------------------------------
	initial begin : sink
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				repeat (sink_hold) @(negedge clk);
				sink_hold = 0;
			end else begin
				w = no_idle ? 0 : $urandom_range(0, 12);
				if (w > 0) begin
					m_tready <= 1'b0;
					repeat (w) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// checker: each accepted word against the oldest expectation
	always @(posedge clk) begin : angle_checker
		angle_pair_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_angles.size() == 0) begin
				errs++;
				$display("%0t: unexpected word %h", $time, m_tdata);
			end else begin
				e = pending_angles.pop_front();
				if (m_tdata[18:0] !== e.roll) begin
					errs++;
					$display("%0t: roll expected %0d actual %0d", $time, e.roll,
						$signed(m_tdata[18:0]));
				end
				if (m_tdata[37:19] !== e.pitch) begin
					errs++;
					$display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
						$signed(m_tdata[37:19]));
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_clamp_corners();
		test_random_settings();
		test_backpressure();
		repeat (200) @(posedge clk);
		if (errs == 0 && pending_angles.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
rtl/rpcf_pkg.sv
rtl/rpcf_ctrl.sv
rtl/rpcf_dp.sv
rtl/roll_pitch_complementary_filter_unit.sv
dv/tb_roll_pitch_complementary_filter_unit.sv
